[hw/rtl/assert_macros.svh]
// Assertion helpers included by the top-level tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tplt_pkg.sv]
package tplt_pkg;

	localparam int FLAG_W = 7;

	localparam logic [7:0] PARAM_BOUNDARY = 8'd16;
	localparam logic [7:0] PARAM_RESPONSE = 8'd17;

	localparam logic [1:0] ACT_PKT       = 2'd0;
	localparam logic [1:0] ACT_ACK_TEL   = 2'd1;
	localparam logic [1:0] ACT_ACK_PARAM = 2'd2;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_MASK   = 1'b1;

	typedef enum logic [3:0] {
		STAT_OK       = 4'd0,
		STAT_PARAM_OK = 4'd1,
		STAT_BAD_FMT  = 4'd2,
		STAT_DISABLED = 4'd3,
		STAT_SHORT    = 4'd4,
		STAT_FILTERED = 4'd5,
		STAT_UNKNOWN  = 4'd6,
		STAT_BAD_LEN  = 4'd7,
		STAT_CRC_ERR  = 4'd8,
		STAT_ACK      = 4'd9
	} status_e;

	typedef enum logic {
		S_IDLE,
		S_CALC
	} fsm_e;

	typedef struct packed {
		logic [1:0]  action;
		logic        mv_ok;
		logic        hdr_ok;
		logic        len_ok;
		logic        crc_ok;
		logic [7:0]  pkt_type;
		logic [15:0] seq;
	} item_t;

	typedef struct packed {
		logic [15:0] prev_seq;
		logic [31:0] good;
		logic [31:0] lost;
		logic [31:0] crc_err;
	} entry_t;

	typedef struct packed {
		logic [FLAG_W-1:0] fresh_bits;
		logic              fresh_any;
		logic              param;
	} flags_t;

	typedef struct packed {
		logic [31:0] recv;
		logic [31:0] lost;
		logic [31:0] crc_err;
	} report_t;

	typedef struct packed {
		status_e     status;
		logic [15:0] dropped;
		logic        wr_en;
		entry_t      entry;
		flags_t      flags;
	} upd_t;

endpackage

[hw/rtl/tplt_stat_mem.sv]
module tplt_stat_mem #(
	parameter int DEPTH = 7,
	parameter int AW = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  tplt_pkg::entry_t   wr_data,
	output tplt_pkg::entry_t   rd_data
);
	import tplt_pkg::*;

	entry_t           mem [DEPTH];
	entry_t           rdata_q;
	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rdata_q : '0;

endmodule

[hw/rtl/tplt_update.sv]
module tplt_update #(
	parameter int STREAM_TYPES = 7
) (
	input  tplt_pkg::item_t                 item,
	input  tplt_pkg::entry_t                entry,
	input  tplt_pkg::flags_t                flags,
	input  logic                            enable,
	input  logic [tplt_pkg::FLAG_W-1:0]     mask,
	output tplt_pkg::upd_t                  upd,
	output tplt_pkg::report_t               report
);
	import tplt_pkg::*;

	logic        is_stream;
	logic [2:0]  bit_idx;
	logic [7:0]  mask_ext;
	logic [7:0]  fresh_set;
	logic        mask_ok;
	logic [15:0] expected;
	logic [15:0] gap;

	assign is_stream = (item.pkt_type >= 8'd1) && (item.pkt_type <= 8'(STREAM_TYPES));
	assign bit_idx   = 3'(item.pkt_type - 8'd1);
	assign mask_ext  = {1'b0, mask};
	assign mask_ok   = is_stream && mask_ext[bit_idx];
	assign fresh_set = 8'd1 << bit_idx;
	assign expected  = entry.prev_seq + 16'd1;
	assign gap       = item.seq - expected;

	always_comb begin
		upd.status  = STAT_BAD_FMT;
		upd.dropped = '0;
		upd.wr_en   = 1'b0;
		upd.entry   = entry;
		upd.flags   = flags;
		case (item.action)
			ACT_ACK_TEL: begin
				upd.flags.fresh_bits = '0;
				upd.flags.fresh_any  = 1'b0;
				upd.status           = STAT_ACK;
			end
			ACT_ACK_PARAM: begin
				upd.flags.param = 1'b0;
				upd.status      = STAT_ACK;
			end
			ACT_PKT: begin
				if (!item.mv_ok) begin
					upd.status = STAT_BAD_FMT;
				end else if (!enable) begin
					upd.status = STAT_DISABLED;
				end else if (!item.hdr_ok) begin
					upd.status = STAT_SHORT;
				end else if (item.pkt_type < PARAM_BOUNDARY && !mask_ok) begin
					upd.status = STAT_FILTERED;
				end else if (is_stream) begin
					if (!item.len_ok) begin
						upd.status = STAT_BAD_LEN;
					end else if (!item.crc_ok) begin
						upd.entry.crc_err = entry.crc_err + 32'd1;
						upd.wr_en         = 1'b1;
						upd.status        = STAT_CRC_ERR;
					end else begin
						// Loss is counted only once the type has a good packet.
						if (entry.good != '0) begin
							upd.dropped    = gap;
							upd.entry.lost = entry.lost + {16'd0, gap};
						end
						upd.entry.prev_seq   = item.seq;
						upd.entry.good       = entry.good + 32'd1;
						upd.flags.fresh_any  = 1'b1;
						upd.flags.fresh_bits = flags.fresh_bits | fresh_set[FLAG_W-1:0];
						upd.wr_en            = 1'b1;
						upd.status           = STAT_OK;
					end
				end else if (item.pkt_type == PARAM_RESPONSE) begin
					if (!item.len_ok) begin
						upd.status = STAT_BAD_LEN;
					end else if (!item.crc_ok) begin
						upd.status = STAT_CRC_ERR;
					end else begin
						upd.flags.param = 1'b1;
						upd.status      = STAT_PARAM_OK;
					end
				end else begin
					upd.status = STAT_UNKNOWN;
				end
			end
			default: begin
				upd.status = STAT_BAD_FMT;
			end
		endcase
	end

	always_comb begin
		if (item.action == ACT_PKT && is_stream) begin
			report.recv    = upd.entry.good;
			report.lost    = upd.entry.lost;
			report.crc_err = upd.entry.crc_err;
		end else begin
			report = '0;
		end
	end

endmodule

[hw/rtl/telemetry_packet_loss_tracker.sv]
// Channel  | Direction | Handshake         | Contents
// s        | in        | s_tvalid/s_tready | descriptor or acknowledge word
// m        | out       | m_tvalid/m_tready | status, loss and statistics word
// cfg      | in        | cfg_we            | telemetry_enable, type_mask
//
// Each word is taken while the per-type stats table is read synchronously;
// the update and write-back follow in S_CALC, and the next word is taken
// only once the write-back is done. After reset the stats read as zero
// through per-entry valid bits; no clearing pass is needed. A result waits
// in the output register; while it is not taken, the update of the
// following word holds.
module telemetry_packet_loss_tracker #(
	parameter int STREAM_TYPES = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [0] magic_version_ok, [1] header_ok, [2] length_ok, [3] crc_ok,
	// [11:4] packet_type, [27:12] seq_number, [31:28] zero
	input  logic [31:0]  s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [3:0] status, [19:4] dropped_now, [51:20] received_count,
	// [83:52] dropped_total, [115:84] crc_error_count, [122:116] new_type_flags,
	// [123] telemetry_pending, [124] param_pending, [127:125] zero
	output logic [127:0] m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [6:0]   cfg_wdata
);
	import tplt_pkg::*;
	`include "assert_macros.svh"

	localparam int IDX_W = (STREAM_TYPES > 1) ? $clog2(STREAM_TYPES) : 1;

	fsm_e               state_q, state_d;
	item_t              item_q, in_item;
	logic [IDX_W-1:0]   idx_q, in_idx;
	logic               in_stream;
	logic               accept;
	logic               load;
	logic               enable_q;
	logic [FLAG_W-1:0]  mask_q;
	flags_t             flags_q;
	entry_t             rd_entry;
	upd_t               upd;
	report_t            report;
	logic               m_tvalid_q;
	logic [127:0]       m_tdata_q;

	assign in_item = '{
		action:   s_tuser,
		mv_ok:    s_tdata[0],
		hdr_ok:   s_tdata[1],
		len_ok:   s_tdata[2],
		crc_ok:   s_tdata[3],
		pkt_type: s_tdata[11:4],
		seq:      s_tdata[27:12]
	};

	assign in_stream = (in_item.pkt_type >= 8'd1) &&
		(in_item.pkt_type <= 8'(STREAM_TYPES));
	assign in_idx = in_stream ? IDX_W'(in_item.pkt_type - 8'd1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				// hold until the output register can take the result
				if (!m_tvalid_q || m_tready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			idx_q  <= in_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			mask_q   <= '1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ENABLE: enable_q <= cfg_wdata[0];
				CFG_MASK:   mask_q   <= cfg_wdata;
				default:    mask_q   <= mask_q;
			endcase
		end
	end

	tplt_stat_mem #(
		.DEPTH(STREAM_TYPES),
		.AW(IDX_W)
	) u_stat_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.wr_en   (load && upd.wr_en),
		.wr_addr (idx_q),
		.wr_data (upd.entry),
		.rd_data (rd_entry)
	);

	tplt_update #(
		.STREAM_TYPES(STREAM_TYPES)
	) u_update (
		.item   (item_q),
		.entry  (rd_entry),
		.flags  (flags_q),
		.enable (enable_q),
		.mask   (mask_q),
		.upd    (upd),
		.report (report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				flags_q    <= upd.flags;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {3'd0, upd.flags.param, upd.flags.fresh_any, upd.flags.fresh_bits,
				report.crc_err, report.lost, report.recv, upd.dropped, upd.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_NEXT(a_accept_to_calc, clk, arst_n, accept, state_q == S_CALC && !s_tready, "word accepted but no update cycle follows")
	`ASSERT_IMPLIES(a_out_from_calc, clk, arst_n, m_tvalid && !$past(m_tvalid), $past(state_q == S_CALC), "result appeared without an update")
	`ASSERT_IMPLIES(a_ack_no_stats, clk, arst_n, m_tvalid && m_tdata[3:0] == STAT_ACK, m_tdata[115:20] == '0 && m_tdata[19:4] == '0, "acknowledge result carries statistics")
	`ASSERT_IMPLIES(a_param_rise, clk, arst_n, $rose(flags_q.param), m_tdata[3:0] == STAT_PARAM_OK, "parameter flag set without a parameter response")

endmodule
